FILE: hw/rtl/mfes_pkg.sv
// ----------------------------------------------------------------------------
// mfes_pkg
// Shared constants, instruction patterns, item kinds and types for the
// frame epilogue scanner.
// ----------------------------------------------------------------------------
package mfes_pkg;

	// cache geometry; CACHE_ENTRIES must be a power of two
	localparam int CACHE_ENTRIES = 256;
	localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CACHE_W       = 32 + 16 + 32;  // {tag, ra offset, sp adjust}

	// front/back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [31:0] LIMIT_RESET = 32'h0020_0000;
	localparam logic [31:0] ADJ_NONE    = 32'hffff_ffff;

	// register index, taken from paddr[2]
	localparam logic REG_SCAN_LIMIT = 1'b0;

	// upper halfword patterns
	localparam logic [15:0] PAT_LW_RA    = 16'h8fbf;
	localparam logic [15:0] PAT_LD_RA    = 16'hdfbf;
	localparam logic [15:0] PAT_LQ_RA    = 16'h7bbf;
	localparam logic [15:0] PAT_ADDIU_SP = 16'h27bd;
	localparam logic [15:0] PAT_LUI_AT   = 16'h3c01;
	localparam logic [15:0] PAT_ORI_AT   = 16'h3421;
	localparam logic [15:0] PAT_ORI_ZERO = 16'h3401;
	// full-word patterns
	localparam logic [31:0] PAT_ADDU_SP  = 32'h03a1_e821;
	localparam logic [31:0] PAT_JR_RA    = 32'h03e0_0008;

	// request opcodes
	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_INSTR = 1'b1;

	// classified item kinds
	localparam int KIND_W = 4;
	localparam logic [KIND_W-1:0] KIND_BEGIN    = 4'd0;
	localparam logic [KIND_W-1:0] KIND_OTHER    = 4'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD_RA  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_ADDIU_SP = 4'd3;
	localparam logic [KIND_W-1:0] KIND_ADDU_SP  = 4'd4;
	localparam logic [KIND_W-1:0] KIND_LUI_AT   = 4'd5;
	localparam logic [KIND_W-1:0] KIND_ORI_AT   = 4'd6;
	localparam logic [KIND_W-1:0] KIND_ORI_ZERO = 4'd7;
	localparam logic [KIND_W-1:0] KIND_JR_RA    = 4'd8;

	// found flag bits
	localparam int FOUND_OFF   = 0;
	localparam int FOUND_ADJ   = 1;
	localparam int FOUND_UPPER = 2;
	localparam int FOUND_LOWER = 3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [31:0]       data;  // return address, or instruction word
	} item_t;

	typedef struct packed {
		logic [15:0] ret_off;
		logic [31:0] frame_adj;
		logic        frame_ok;
		logic        from_cache;
	} result_t;

	function automatic logic [IDX_W-1:0] slot_of(input logic [31:0] addr);
		logic [31:0] word;
		word = (addr >> 2) & 32'(CACHE_ENTRIES - 1);
		return word[IDX_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/mfes_ram.sv
// ----------------------------------------------------------------------------
// mfes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/mfes_front.sv
// ----------------------------------------------------------------------------
// mfes_front
// Accepts requests, classifies instruction words and queues them for the
// scan engine.
// ----------------------------------------------------------------------------
module mfes_front import mfes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        in_opcode,
	input  logic [31:0] in_return_address,
	input  logic [31:0] in_instruction,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               push;
	item_t              cls;
	logic [15:0]        hi;

	assign in_ready = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign hi       = in_instruction[31:16];

	always_comb begin
		cls.data = in_instruction;
		cls.kind = KIND_OTHER;
		if (in_opcode == OP_BEGIN) begin
			cls.kind = KIND_BEGIN;
			cls.data = in_return_address;
		end else if (hi == PAT_LW_RA || hi == PAT_LD_RA || hi == PAT_LQ_RA) begin
			cls.kind = KIND_LOAD_RA;
		end else if (hi == PAT_ADDIU_SP) begin
			cls.kind = KIND_ADDIU_SP;
		end else if (in_instruction == PAT_ADDU_SP) begin
			cls.kind = KIND_ADDU_SP;
		end else if (hi == PAT_LUI_AT) begin
			cls.kind = KIND_LUI_AT;
		end else if (hi == PAT_ORI_AT) begin
			cls.kind = KIND_ORI_AT;
		end else if (hi == PAT_ORI_ZERO) begin
			cls.kind = KIND_ORI_ZERO;
		end else if (in_instruction == PAT_JR_RA) begin
			cls.kind = KIND_JR_RA;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/mfes_back.sv
// ----------------------------------------------------------------------------
// mfes_back
// Scan engine: cache lookup, per-word scan state, cache fill and result
// register.
// ----------------------------------------------------------------------------
module mfes_back import mfes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] scan_limit,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_result
);

	// lookup stage
	logic              look_q;
	logic [31:0]       look_ra_q;
	logic [IDX_W-1:0]  look_idx;
	logic [CACHE_W-1:0] rd_data;
	logic              hit;
	logic              look_go;
	logic              look_fin;

	// scan state
	logic              active_q;
	logic [31:0]       start_q;
	logic [31:0]       addr_q;
	logic [31:0]       end_q;
	logic [3:0]        flags_q;
	logic [15:0]       upper_q;
	logic [15:0]       lower_q;
	logic [15:0]       off_q;
	logic [31:0]       adj_q;

	logic [3:0]        step_flags;
	logic [15:0]       step_upper;
	logic [15:0]       step_lower;
	logic [15:0]       step_off;
	logic [31:0]       step_adj;
	logic [31:0]       step_end;
	logic [31:0]       step_addr;
	logic [31:0]       fold_adj;
	logic              step_fin;
	logic [15:0]       imm;

	logic [CACHE_ENTRIES-1:0] valid_q;

	logic              out_free;
	logic              is_begin;
	logic              emit;
	result_t           emit_res;
	logic              cw_en;
	logic [IDX_W-1:0]  cw_idx;
	logic [CACHE_W-1:0] cw_data;
	logic              scan_done;
	logic              out_valid_q;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign is_begin  = (q_item.kind == KIND_BEGIN);
	assign q_pop     = q_valid && !look_q && out_free;
	assign look_go   = look_q && out_free;
	assign look_idx  = slot_of(look_ra_q);
	assign hit       = valid_q[look_idx] && (rd_data[CACHE_W-1 -: 32] == look_ra_q);
	assign look_fin  = look_ra_q >= scan_limit;
	assign scan_done = q_pop && !is_begin && active_q && step_fin;
	assign imm       = q_item.data[15:0];

	// one scan step on the head word
	always_comb begin
		step_flags = flags_q;
		step_upper = upper_q;
		step_lower = lower_q;
		step_off   = off_q;
		step_adj   = adj_q;
		step_end   = end_q;
		case (q_item.kind)
			KIND_LOAD_RA: begin
				step_off              = imm;
				step_flags[FOUND_OFF] = 1'b1;
			end
			KIND_ADDIU_SP: begin
				step_adj              = {16'h0000, imm};
				step_flags[FOUND_ADJ] = 1'b1;
			end
			KIND_ADDU_SP: begin
				step_adj              = '0;
				step_flags[FOUND_ADJ] = 1'b1;
			end
			KIND_LUI_AT: begin
				step_upper              = imm;
				step_lower              = '0;
				step_flags[FOUND_UPPER] = 1'b1;
			end
			KIND_ORI_AT: begin
				step_lower              = imm;
				step_flags[FOUND_LOWER] = 1'b1;
			end
			KIND_ORI_ZERO: begin
				step_lower              = imm;
				step_upper              = '0;
				step_flags[FOUND_LOWER] = 1'b1;
			end
			KIND_JR_RA: begin
				// stop after the delay slot
				step_end = addr_q + 32'd8;
			end
			default: begin
			end
		endcase
		step_addr = addr_q + 32'd4;
		step_fin  = (step_flags[FOUND_OFF] && step_flags[FOUND_ADJ])
			|| (step_addr >= step_end);
		// addu form: frame size comes from the $at constant
		if (step_adj == '0 && (step_flags[FOUND_UPPER] || step_flags[FOUND_LOWER])) begin
			fold_adj = {step_upper, step_lower};
		end else begin
			fold_adj = step_adj;
		end
	end

	// result and cache fill select
	always_comb begin
		emit     = 1'b0;
		emit_res = '0;
		cw_en    = 1'b0;
		cw_idx   = slot_of(start_q);
		cw_data  = {start_q, step_off, fold_adj};
		if (look_go && hit) begin
			emit                = 1'b1;
			emit_res.ret_off    = rd_data[47:32];
			emit_res.frame_adj  = rd_data[31:0];
			emit_res.from_cache = 1'b1;
		end else if (look_go && look_fin) begin
			emit               = 1'b1;
			emit_res.ret_off   = '0;
			emit_res.frame_adj = ADJ_NONE;
			cw_en              = 1'b1;
			cw_idx             = look_idx;
			cw_data            = {look_ra_q, 16'h0000, ADJ_NONE};
		end else if (scan_done) begin
			emit               = 1'b1;
			emit_res.ret_off   = step_off;
			emit_res.frame_adj = fold_adj;
			cw_en              = 1'b1;
		end
		emit_res.frame_ok = !emit_res.frame_adj[31] && (emit_res.frame_adj != '0);
	end

	mfes_ram #(
		.WIDTH (CACHE_W),
		.DEPTH (CACHE_ENTRIES)
	) u_cache (
		.clk     (clk),
		.wr_en   (cw_en),
		.wr_addr (cw_idx),
		.wr_data (cw_data),
		.rd_en   (q_pop && is_begin),
		.rd_addr (slot_of(q_item.data)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q      <= 1'b0;
			look_ra_q   <= '0;
			active_q    <= 1'b0;
			start_q     <= '0;
			addr_q      <= '0;
			end_q       <= '0;
			flags_q     <= '0;
			upper_q     <= '0;
			lower_q     <= '0;
			off_q       <= '0;
			adj_q       <= ADJ_NONE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (look_go) begin
				look_q <= 1'b0;
				if (hit) begin
					active_q <= 1'b0;
				end else begin
					start_q  <= look_ra_q;
					addr_q   <= look_ra_q;
					end_q    <= scan_limit;
					flags_q  <= '0;
					upper_q  <= '0;
					lower_q  <= '0;
					off_q    <= '0;
					adj_q    <= ADJ_NONE;
					active_q <= !look_fin;
				end
			end else if (q_pop) begin
				if (is_begin) begin
					look_q    <= 1'b1;
					look_ra_q <= q_item.data;
				end else if (active_q) begin
					addr_q   <= step_addr;
					end_q    <= step_end;
					flags_q  <= step_flags;
					upper_q  <= step_upper;
					lower_q  <= step_lower;
					off_q    <= step_off;
					adj_q    <= step_adj;
					active_q <= !step_fin;
				end
			end
			if (cw_en) begin
				valid_q[cw_idx] <= 1'b1;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			out_result <= emit_res;
		end
	end

endmodule

FILE: hw/rtl/mips_frame_epilogue_scanner.sv
// ----------------------------------------------------------------------------
// mips_frame_epilogue_scanner
// Finds the saved $ra offset and the stack adjustment of a MIPS function
// epilogue, with a direct-mapped cache of earlier answers.
// ----------------------------------------------------------------------------
// A begin request (tuser = 0) carries a return address; instruction requests
// (tuser = 1) carry the words that follow it, one per request, in address
// order. A cache hit answers with from_cache set; a miss starts a scan that
// answers once both the $ra load and the $sp adjustment are seen, after the
// delay slot of jr $ra, or when the scan address reaches scan_limit_address
// (sampled at the begin's tag compare). Instruction requests arriving with no scan running
// are dropped. Timing: the input side takes one request per cycle into a
// four-entry queue; the scan engine retires one instruction word per cycle
// and handles a begin with a registered cache RAM read and then a tag
// compare. A result leaves through an output register; while a result
// sits there unaccepted the engine takes nothing from the queue, and the
// input side keeps taking requests until the queue is full. Cache valid bits
// are flip-flops cleared by reset; there is no clearing pass, so the block
// is ready right after reset.
// ----------------------------------------------------------------------------
module mips_frame_epilogue_scanner import mfes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] return_address, [63:32] instruction
	input  logic        s_tuser,   // [0] opcode
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] ret_off, [47:16] frame_adj,
	                               // [48] frame_ok, [55:49] zero
	output logic        m_tuser,   // [0] from_cache
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] limit_q;
	logic        q_valid;
	item_t       q_item;
	logic        q_pop;
	result_t     res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SCAN_LIMIT) ? limit_q : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SCAN_LIMIT) begin
			limit_q <= pwdata;
		end
	end

	// classify and queue
	mfes_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.in_opcode         (s_tuser),
		.in_return_address (s_tdata[31:0]),
		.in_instruction    (s_tdata[63:32]),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop)
	);

	// lookup, scan, fill, result register
	mfes_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_limit (limit_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (res)
	);

	assign m_tdata = {7'b0000000, res.frame_ok, res.frame_adj, res.ret_off};
	assign m_tuser = res.from_cache;

endmodule
